// File: design/rgb565_to_yuv420_pixel_pair_defines.svh
// Assertion macros shared by the pixel-pair converter
`ifndef RGB565_TO_YUV420_PIXEL_PAIR_DEFINES_SVH
`define RGB565_TO_YUV420_PIXEL_PAIR_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low
`define R2Y_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("r2y: same-cycle check failed");

// Next-cycle implication, checked on clk, quiet while rst_n is low
`define R2Y_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("r2y: next-cycle check failed");

`endif

// File: design/r2y_pkg.sv
// Package: coefficients, widths and lane types of the RGB565 to YUV converter
`default_nettype none
package r2y_pkg;

  localparam int PIX_W  = 16;
  localparam int CH_W   = 8;
  localparam int SUM_W  = 18;
  localparam int DIFF_W = 9;
  localparam int PROD_W = 20;
  localparam int SHIFT  = 10;

  localparam logic [9:0] COEF_YR = 10'd306;
  localparam logic [9:0] COEF_YG = 10'd601;
  localparam logic [9:0] COEF_YB = 10'd116;
  localparam logic [9:0] COEF_U  = 10'd577;
  localparam logic [9:0] COEF_V  = 10'd730;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;
  localparam logic [7:0] CHROMA_MAX    = 8'd255;

  // What one luma lane hands on: luma plus the expanded R and B of its pixel
  typedef struct packed {
    logic [CH_W-1:0] y;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] b;
  } lane_t;

endpackage
`default_nettype wire

// File: design/rgb565_to_yuv420_pixel_pair.sv
// Path: an accepted input item passes each stage register in turn before its result item is on out_*.
// Throughput: one pixel pair per clock while the sink does not stall; the
//   three-stage pipeline (luma lanes, chroma products, clamp into the output
//   register) advances whenever the output register is empty or being taken.
// Reset: synchronous, active low rst_n clears all stage valid bits; payload
//   registers are not reset.
`default_nettype none
`include "rgb565_to_yuv420_pixel_pair_defines.svh"
module rgb565_to_yuv420_pixel_pair (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pixel_first,
  input  wire logic [15:0] in_pixel_second,
  input  wire logic        in_row_even,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_luma_first,
  output logic [7:0]       out_luma_second,
  output logic [7:0]       out_chroma_u,
  output logic [7:0]       out_chroma_v,
  output logic             out_chroma_valid
);

  // Pipeline advance: the whole pipe moves unless a finished item waits in
  // the output register and the sink stalls. Bubbles in the pipe are
  // squeezed out only at the output, which is enough for one item a clock while the sink takes results.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: two luma lanes side by side, one per pixel of the pair
  r2y_pkg::lane_t lane0, lane1;

  r2y_luma_lane u_lane0 (
    .clk   (clk),
    .en    (en),
    .pixel (in_pixel_first),
    .q     (lane0)
  );

  r2y_luma_lane u_lane1 (
    .clk   (clk),
    .en    (en),
    .pixel (in_pixel_second),
    .q     (lane1)
  );

  // Stage 2 (products) and clamp: chroma comes from the first pixel only
  logic [7:0] u_sat, v_sat;

  r2y_chroma u_chroma (
    .clk  (clk),
    .en   (en),
    .lane (lane0),
    .u    (u_sat),
    .v    (v_sat)
  );

  // Control pipeline: valid and even-row flag follow the payload
  logic v1_r, v2_r, out_valid_r;
  logic e1_r, e2_r;
  // Luma rides along stage 2 while the chroma products are formed
  logic [7:0] y0_2_r, y1_2_r;
  // Output register
  logic [7:0] ly0_r, ly1_r, cu_r, cv_r, cu_nxt, cv_nxt;
  logic       cval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Odd rows carry no chroma sample: drop U and V to zero
  always_comb begin
    cu_nxt = e2_r ? u_sat : 8'd0;
    cv_nxt = e2_r ? v_sat : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r   <= in_row_even;
      e2_r   <= e1_r;
      y0_2_r <= lane0.y;
      y1_2_r <= lane1.y;
      ly0_r  <= y0_2_r;
      ly1_r  <= y1_2_r;
      cu_r   <= cu_nxt;
      cv_r   <= cv_nxt;
      cval_r <= e2_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma_first   = ly0_r;
  assign out_luma_second  = ly1_r;
  assign out_chroma_u     = cu_r;
  assign out_chroma_v     = cv_r;
  assign out_chroma_valid = cval_r;

  // A result with no chroma sample carries zero U and V
  `R2Y_ASSERT_NOW(a_chroma_zero, out_valid && !out_chroma_valid,
                  out_chroma_u == 8'd0 && out_chroma_v == 8'd0)
  // Luma of full-scale white tops out at 250
  `R2Y_ASSERT_NOW(a_luma_range, out_valid,
                  out_luma_first <= 8'd250 && out_luma_second <= 8'd250)
  // An item in the last stage reaches the output when the pipe advances
  `R2Y_ASSERT_NEXT(a_stage_to_out, v2_r && en, out_valid)
  // A waiting result that is stalled stays presented
  `R2Y_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_luma_first))

endmodule
`default_nettype wire

// File: design/r2y_luma_lane.sv
// One luma lane: expand an RGB565 pixel and register its luma, R and B
`default_nettype none
module r2y_luma_lane (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [r2y_pkg::PIX_W-1:0] pixel,
  output r2y_pkg::lane_t                q
);

  logic [7:0]                r8, g8, b8;
  logic [r2y_pkg::SUM_W-1:0] sum;
  r2y_pkg::lane_t            q_r, q_nxt;

  always_comb begin
    r8  = {pixel[15:11], 3'b000};
    g8  = {pixel[10:5], 2'b00};
    b8  = {pixel[4:0], 3'b000};
    sum = r2y_pkg::SUM_W'(r8) * r2y_pkg::SUM_W'(r2y_pkg::COEF_YR)
        + r2y_pkg::SUM_W'(g8) * r2y_pkg::SUM_W'(r2y_pkg::COEF_YG)
        + r2y_pkg::SUM_W'(b8) * r2y_pkg::SUM_W'(r2y_pkg::COEF_YB);
    q_nxt.y = sum[r2y_pkg::SHIFT +: r2y_pkg::CH_W];
    q_nxt.r = r8;
    q_nxt.b = b8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// File: design/r2y_chroma.sv
// Chroma merge: weight B-Y and R-Y of the first lane, then floor, offset and clamp
`default_nettype none
module r2y_chroma (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  r2y_pkg::lane_t                lane,
  output logic [r2y_pkg::CH_W-1:0]      u,
  output logic [r2y_pkg::CH_W-1:0]      v
);

  logic signed [r2y_pkg::DIFF_W-1:0] du, dv;
  logic signed [r2y_pkg::PROD_W-1:0] pu_r, pv_r, pu_nxt, pv_nxt;

  always_comb begin
    du = $signed({1'b0, lane.b}) - $signed({1'b0, lane.y});
    dv = $signed({1'b0, lane.r}) - $signed({1'b0, lane.y});
    pu_nxt = $signed({1'b0, r2y_pkg::COEF_U}) * r2y_pkg::PROD_W'(du);
    pv_nxt = $signed({1'b0, r2y_pkg::COEF_V}) * r2y_pkg::PROD_W'(dv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r <= pu_nxt;
      pv_r <= pv_nxt;
    end
  end

  // Floor shift keeps the top bits; add offset and saturate to 0..255
  function automatic logic [7:0] sat_chroma(input logic signed [r2y_pkg::PROD_W-1:0] p);
    logic signed [10:0] c;
    c = 11'($signed(p[r2y_pkg::PROD_W-1:r2y_pkg::SHIFT])) + 11'($signed({3'b000,
        r2y_pkg::CHROMA_OFFSET}));
    if (c < 0) begin
      sat_chroma = 8'd0;
    end else if (c > $signed({3'b000, r2y_pkg::CHROMA_MAX})) begin
      sat_chroma = r2y_pkg::CHROMA_MAX;
    end else begin
      sat_chroma = c[7:0];
    end
  endfunction

  always_comb begin
    u = sat_chroma(pu_r);
    v = sat_chroma(pv_r);
  end

endmodule
`default_nettype wire
